// File: rtl/core/tlp_pkg.sv
// Shared types, widths and constants for the two-link planar inverse kinematics block.
package tlp_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 16;
    localparam int LINK_W   = 15;
    localparam int ANG_W    = 18;
    localparam int SQ_W     = 32;
    localparam int LSQ_W    = 30;
    localparam int NUM_W    = 35;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int CW       = 36;
    localparam int ZW       = 28;
    localparam int EXP_W    = 5;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 32;

    // Pipeline depths.
    localparam int NORM_STEPS   = 5;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 23;
    localparam int LANES        = 3;
    localparam int NUM_STAGES   = 4 + NORM_STEPS + SQRT_STEPS + 1 + CORDIC_STEPS;

    // Lane assignment inside the rotation pipeline.
    localparam int LANE_SHO  = 0;
    localparam int LANE_ELB  = 1;
    localparam int LANE_BASE = 2;

    // Register indexes on the configuration port.
    localparam logic REG_LINK_ONE = 1'b0;
    localparam logic REG_LINK_TWO = 1'b1;

    // Register reset values.
    localparam logic [LINK_W-1:0] LINK_ONE_RST = 15'd1280;
    localparam logic [LINK_W-1:0] LINK_TWO_RST = 15'd512;

    // Angles in units of 2^-16 degree.
    localparam logic signed [ZW-1:0] DEG90  = 28'sd5898240;
    localparam logic signed [ZW-1:0] DEG180 = 28'sd11796480;
    localparam logic signed [ZW-1:0] HALF_LSB = 28'sd128;
    localparam int PRESCALE_SH = 14;

    // One vectoring lane: coordinates and accumulated angle.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    // Per-item data that rides along the normalize and square root stages.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      clamp;
        logic                      flag;
        logic                      zero1;
        logic                      zero3;
        logic                      sat;
        logic                      n1_pos;
        logic                      n3_pos;
        logic signed [NUM_W-1:0]   n1;
        logic signed [NUM_W-1:0]   n3;
    } t_side;

    // Per-item data that rides along the rotation stages.
    typedef struct packed {
        logic clamp;
        logic flag;
        logic neg;
    } t_fin;

    // Arctangent of 2^-i in 2^-16 degree.
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 28'sd2949120;
            1:       v = 28'sd1740967;
            2:       v = 28'sd919879;
            3:       v = 28'sd466945;
            4:       v = 28'sd234379;
            5:       v = 28'sd117266;
            6:       v = 28'sd58666;
            7:       v = 28'sd29335;
            8:       v = 28'sd14668;
            9:       v = 28'sd7334;
            10:      v = 28'sd3667;
            11:      v = 28'sd1833;
            12:      v = 28'sd917;
            13:      v = 28'sd458;
            14:      v = 28'sd229;
            15:      v = 28'sd115;
            16:      v = 28'sd57;
            17:      v = 28'sd29;
            18:      v = 28'sd14;
            19:      v = 28'sd7;
            20:      v = 28'sd4;
            21:      v = 28'sd2;
            22:      v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/tlp_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side channel.
module tlp_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [tlp_pkg::RAD_W-1:0]       i_rad,
    input  tlp_pkg::t_side                  i_side,
    output logic [tlp_pkg::ROOT_W-1:0]      o_root,
    output tlp_pkg::t_side                  o_side
);
    import tlp_pkg::*;

    logic [RAD_W-1:0] r_rem  [SQRT_STEPS];
    logic [RAD_W-1:0] r_res  [SQRT_STEPS];
    t_side            r_side [SQRT_STEPS];

    // Each stage tries one bit of the root against the remaining radicand.
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - i));
        logic [RAD_W-1:0] w_rem;
        logic [RAD_W-1:0] w_res;
        logic [RAD_W-1:0] w_try;
        logic [RAD_W-1:0] n_rem;
        logic [RAD_W-1:0] n_res;
        t_side            w_side;

        if (i == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_res  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[i-1];
            assign w_res  = r_res[i-1];
            assign w_side = r_side[i-1];
        end

        assign w_try = w_res + BIT;

        always_comb begin
            if (w_rem >= w_try) begin
                n_rem = w_rem - w_try;
                n_res = (w_res >> 1) + BIT;
            end else begin
                n_rem = w_rem;
                n_res = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_res[i]  <= n_res;
                r_side[i] <= w_side;
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][ROOT_W-1:0];
    assign o_side = r_side[SQRT_STEPS-1];

endmodule

// File: rtl/core/tlp_cordic.sv
// Pipelined vectoring CORDIC, three lanes in lockstep, one micro-rotation per stage.
module tlp_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  tlp_pkg::t_vec [tlp_pkg::LANES-1:0]  i_lane,
    input  tlp_pkg::t_fin                       i_fin,
    output tlp_pkg::t_vec [tlp_pkg::LANES-1:0]  o_lane,
    output tlp_pkg::t_fin                       o_fin
);
    import tlp_pkg::*;

    t_vec [LANES-1:0] r_lane [CORDIC_STEPS];
    t_fin             r_fin  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        t_vec [LANES-1:0] w_in;
        t_vec [LANES-1:0] n_lane;
        t_fin             w_fin;

        if (i == 0) begin : g_first
            assign w_in  = i_lane;
            assign w_fin = i_fin;
        end else begin : g_next
            assign w_in  = r_lane[i-1];
            assign w_fin = r_fin[i-1];
        end

        // Rotate toward the x axis; a lane that reached y of zero stays put.
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            always_comb begin
                n_lane[l] = w_in[l];
                if (w_in[l].y > 0) begin
                    n_lane[l].x = w_in[l].x + (w_in[l].y >>> i);
                    n_lane[l].y = w_in[l].y - (w_in[l].x >>> i);
                    n_lane[l].z = w_in[l].z + atan_entry(i);
                end else if (w_in[l].y < 0) begin
                    n_lane[l].x = w_in[l].x - (w_in[l].y >>> i);
                    n_lane[l].y = w_in[l].y + (w_in[l].x >>> i);
                    n_lane[l].z = w_in[l].z - atan_entry(i);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lane[i] <= n_lane;
                r_fin[i]  <= w_fin;
            end
        end
    end

    assign o_lane = r_lane[CORDIC_STEPS-1];
    assign o_fin  = r_fin[CORDIC_STEPS-1];

endmodule

// File: rtl/core/two_link_planar_ik.sv
// Throughput: one target point per cycle while not stalled; the 32-stage square root and 23-stage CORDIC set
// the depth, and the whole pipeline advances together when the last stage is empty or the output register can load.
// A full output register stalls the pipeline only when the last stage holds a result.
// Reset (synchronous, active low) clears all valid bits and restores the link lengths.
// Top level of the two-link planar inverse kinematics block.
module two_link_planar_ik (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Target point stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // target_x, target_y
    // Joint angle stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // shoulder_angle, elbow_angle
    output logic [tlp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // reach_clamped, acos_saturated
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tlp_pkg::CFG_AW-1:0]          paddr,
    input  logic [tlp_pkg::CFG_DW-1:0]          pwdata,
    output logic [tlp_pkg::CFG_DW-1:0]          prdata,
    output logic                                pready
);
    import tlp_pkg::*;

    // Configuration registers and their derived squares.
    logic [LINK_W-1:0] r_link_one;
    logic [LINK_W-1:0] r_link_two;
    logic [LSQ_W-1:0]  r_sq1;
    logic [LSQ_W-1:0]  r_sq2;
    logic [LSQ_W-1:0]  r_diff2;
    logic [SQ_W-1:0]   r_reach2;
    logic [LINK_W:0]   w_reach;
    logic [LINK_W-1:0] w_diff;
    logic              w_cfg_wr;
    logic              w_cfg_idx;

    // Pipeline control.
    logic [NUM_STAGES-1:0] r_vld;
    logic                  w_en;
    logic                  w_out_load;
    logic                  w_in_acc;

    // Stage 0 to stage 3 payload.
    logic signed [COORD_W-1:0] r_s0_x, r_s0_y;
    logic signed [COORD_W-1:0] r_s1_x, r_s1_y;
    logic [SQ_W-1:0]           r_s1_s2;
    logic signed [SQ_W-1:0]    w_xx, w_yy;
    logic signed [COORD_W-1:0] r_s2_x, r_s2_y;
    logic                      r_s2_clamp, r_s2_sat, r_s2_z1, r_s2_z3;
    logic signed [NUM_W-1:0]   r_s2_n1, r_s2_n3;
    logic [SQ_W-1:0]           r_s2_km1, r_s2_km2, r_s2_big;
    logic [SQ_W-1:0]           w_q;
    t_side                     r_s3_side;
    logic [RAD_W-1:0]          r_s3_k, r_s3_p;

    // Normalize stages.
    t_side            r_nm_side [NORM_STEPS];
    logic [RAD_W-1:0] r_nm_p    [NORM_STEPS];
    logic [RAD_W-1:0] r_nm_k    [NORM_STEPS];
    logic [EXP_W-1:0] r_nm_e    [NORM_STEPS];

    // Square root output and rotation setup.
    logic [ROOT_W-1:0]  w_root;
    t_side              w_sq_side;
    t_vec [LANES-1:0]   n_cs_lane, r_cs_lane;
    t_fin               n_cs_fin, r_cs_fin;
    t_vec [LANES-1:0]   w_cz_lane;
    t_fin               w_cz_fin;

    // Output register.
    logic                      r_out_vld;
    logic signed [ANG_W-1:0]   r_out_sho, r_out_elb;
    logic                      r_out_clamp, r_out_flag;
    logic signed [ZW-1:0]      w_phi1, w_phi3, w_sho, w_elb;

    // Setup of one acos lane as an angle of (n, root) in the upper half plane.
    function automatic t_vec upper_setup(input logic zero, input logic sat,
                                         input logic npos,
                                         input logic signed [NUM_W-1:0] n,
                                         input logic [ROOT_W-1:0] root);
        t_vec v;
        v.x = '0;
        v.y = '0;
        v.z = '0;
        if (zero) begin
            v.z = '0;
        end else if (sat) begin
            v.z = npos ? '0 : DEG180;
        end else if (root == '0) begin
            v.z = n[NUM_W-1] ? DEG180 : '0;
        end else if (n[NUM_W-1]) begin
            v.x = CW'({1'b0, root});
            v.y = -(CW'(n));
            v.z = DEG90;
        end else begin
            v.x = CW'(n);
            v.y = CW'({1'b0, root});
        end
        return v;
    endfunction

    // Configuration write and read.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[CFG_AW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_one <= LINK_ONE_RST;
            r_link_two <= LINK_TWO_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_LINK_ONE: r_link_one <= pwdata[LINK_W-1:0];
                REG_LINK_TWO: r_link_two <= pwdata[LINK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_LINK_ONE: prdata = CFG_DW'(r_link_one);
            REG_LINK_TWO: prdata = CFG_DW'(r_link_two);
            default:      prdata = '0;
        endcase
    end

    // Squares of the link lengths, refreshed every cycle.
    assign w_reach = {1'b0, r_link_one} + {1'b0, r_link_two};
    assign w_diff  = (r_link_one > r_link_two) ? (r_link_one - r_link_two)
                                               : (r_link_two - r_link_one);

    always_ff @(posedge i_clk) begin
        r_sq1    <= r_link_one * r_link_one;
        r_sq2    <= r_link_two * r_link_two;
        r_diff2  <= w_diff * w_diff;
        r_reach2 <= w_reach * w_reach;
    end

    // The pipeline moves unless the last stage holds a result the output cannot take.
    assign w_out_load    = r_vld[NUM_STAGES-1] && (!r_out_vld || m_axis_tready);
    assign w_en          = !r_vld[NUM_STAGES-1] || w_out_load;
    assign s_axis_tready = w_en && i_rst_n;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], w_in_acc};
        end
    end

    // Stage 0: capture the target point.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_x <= s_axis_tdata[COORD_W-1:0];
            r_s0_y <= s_axis_tdata[2*COORD_W-1:COORD_W];
        end
    end

    // Stage 1: squared radius.
    assign w_xx = r_s0_x * r_s0_x;
    assign w_yy = r_s0_y * r_s0_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x  <= r_s0_x;
            r_s1_y  <= r_s0_y;
            r_s1_s2 <= SQ_W'(w_xx) + SQ_W'(w_yy);
        end
    end

    // Stage 2: reach clamp, acos numerators and the factors of the radicand.
    assign w_q = (r_s1_s2 > r_reach2) ? r_reach2 : r_s1_s2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            r_s2_clamp <= r_s1_s2 > r_reach2;
            r_s2_sat   <= w_q < SQ_W'(r_diff2);
            r_s2_z1    <= (r_link_one == '0) || (w_q == '0);
            r_s2_z3    <= (r_link_one == '0) || (r_link_two == '0);
            r_s2_n1    <= NUM_W'(r_sq1) + NUM_W'(w_q) - NUM_W'(r_sq2);
            r_s2_n3    <= NUM_W'(r_sq1) + NUM_W'(r_sq2) - NUM_W'(w_q);
            r_s2_km1   <= r_reach2 - w_q;
            r_s2_km2   <= w_q - SQ_W'(r_diff2);
            r_s2_big   <= (w_q > SQ_W'(r_sq2)) ? w_q : SQ_W'(r_sq2);
        end
    end

    // Stage 3: radicand and the magnitude that sets the normalizing shift.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_side.x      <= r_s2_x;
            r_s3_side.y      <= r_s2_y;
            r_s3_side.clamp  <= r_s2_clamp;
            r_s3_side.flag   <= r_s2_sat && !(r_s2_z1 && r_s2_z3);
            r_s3_side.zero1  <= r_s2_z1;
            r_s3_side.zero3  <= r_s2_z3;
            r_s3_side.sat    <= r_s2_sat;
            r_s3_side.n1_pos <= !r_s2_n1[NUM_W-1] && (r_s2_n1 != '0);
            r_s3_side.n3_pos <= !r_s2_n3[NUM_W-1] && (r_s2_n3 != '0);
            r_s3_side.n1     <= r_s2_n1;
            r_s3_side.n3     <= r_s2_n3;
            r_s3_k           <= r_s2_km1 * r_s2_km2;
            r_s3_p           <= RAD_W'(r_sq1 * r_s2_big);
        end
    end

    // Normalize: binary search for the shift, applied to radicand and numerators.
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int STEP = 1 << (NORM_STEPS - 1 - j);
        localparam int TH   = 58 - 2 * STEP;
        t_side            w_side;
        t_side            n_side;
        logic [RAD_W-1:0] w_p, w_k;
        logic [EXP_W-1:0] w_e;
        logic             w_take;

        if (j == 0) begin : g_first
            assign w_side = r_s3_side;
            assign w_p    = r_s3_p;
            assign w_k    = r_s3_k;
            assign w_e    = '0;
        end else begin : g_next
            assign w_side = r_nm_side[j-1];
            assign w_p    = r_nm_p[j-1];
            assign w_k    = r_nm_k[j-1];
            assign w_e    = r_nm_e[j-1];
        end

        assign w_take = ((w_p >> TH) == '0) &&
                        (({1'b0, w_e} + (EXP_W + 1)'(STEP)) <= (EXP_W + 1)'(30));

        always_comb begin
            n_side = w_side;
            if (w_take) begin
                n_side.n1 = w_side.n1 <<< STEP;
                n_side.n3 = w_side.n3 <<< STEP;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nm_side[j] <= n_side;
                r_nm_p[j]    <= w_take ? (w_p << (2 * STEP)) : w_p;
                r_nm_k[j]    <= w_take ? (w_k << (2 * STEP)) : w_k;
                r_nm_e[j]    <= w_take ? (w_e + EXP_W'(STEP)) : w_e;
            end
        end
    end

    // Square root of the normalized radicand.
    tlp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_nm_k[NORM_STEPS-1]),
        .i_side (r_nm_side[NORM_STEPS-1]),
        .o_root (w_root),
        .o_side (w_sq_side)
    );

    // Setup: pick the vector and start angle of each lane.
    always_comb begin
        n_cs_lane[LANE_SHO] = upper_setup(w_sq_side.zero1, w_sq_side.sat, w_sq_side.n1_pos,
                                          w_sq_side.n1, w_root);
        n_cs_lane[LANE_ELB] = upper_setup(w_sq_side.zero3, w_sq_side.sat, w_sq_side.n3_pos,
                                          w_sq_side.n3, w_root);
        n_cs_lane[LANE_BASE] = '0;
        n_cs_fin.clamp = w_sq_side.clamp;
        n_cs_fin.flag  = w_sq_side.flag;
        n_cs_fin.neg   = w_sq_side.x[COORD_W-1];
        if (w_sq_side.x[COORD_W-1]) begin
            n_cs_lane[LANE_BASE].x = -(CW'(w_sq_side.x) <<< PRESCALE_SH);
            n_cs_lane[LANE_BASE].y = -(CW'(w_sq_side.y) <<< PRESCALE_SH);
            n_cs_lane[LANE_BASE].z = DEG180;
        end else if (w_sq_side.x != '0) begin
            n_cs_lane[LANE_BASE].x = CW'(w_sq_side.x) <<< PRESCALE_SH;
            n_cs_lane[LANE_BASE].y = CW'(w_sq_side.y) <<< PRESCALE_SH;
        end else if (w_sq_side.y[COORD_W-1]) begin
            n_cs_lane[LANE_BASE].z = -DEG90;
        end else if (w_sq_side.y != '0) begin
            n_cs_lane[LANE_BASE].z = DEG90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cs_lane <= n_cs_lane;
            r_cs_fin  <= n_cs_fin;
        end
    end

    // Angles of all three lanes.
    tlp_cordic u_cordic (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lane (r_cs_lane),
        .i_fin  (r_cs_fin),
        .o_lane (w_cz_lane),
        .o_fin  (w_cz_fin)
    );

    // Combine the joint angles and round to 1/256 degree.
    assign w_phi1 = w_cz_fin.neg ? -w_cz_lane[LANE_SHO].z : w_cz_lane[LANE_SHO].z;
    assign w_phi3 = w_cz_fin.neg ? -w_cz_lane[LANE_ELB].z : w_cz_lane[LANE_ELB].z;
    assign w_sho  = w_phi1 + w_cz_lane[LANE_BASE].z + HALF_LSB;
    assign w_elb  = w_phi3 - DEG180 + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sho   <= w_sho[ANG_W+7:8];
            r_out_elb   <= w_elb[ANG_W+7:8];
            r_out_clamp <= w_cz_fin.clamp;
            r_out_flag  <= w_cz_fin.flag;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - 2 * ANG_W)'(0), r_out_elb, r_out_sho};
    assign m_axis_tuser  = {r_out_flag, r_out_clamp};

endmodule

// File: rtl/core/tlp_checker.sv
// Port-level checker for the two-link planar inverse kinematics block, with its bind.
module tlp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic [tlp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
    // Reset empties the output side.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // With no result waiting, the block always takes a new transaction.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind two_link_planar_ik tlp_checker u_tlp_checker (.*);

// File: bench/two_link_planar_ik_tb.sv
// Self-checking testbench for the two-link planar inverse kinematics block.
module two_link_planar_ik_tb;
    import tlp_pkg::*;

    // Angle and scale constants of the predictor, angles in 2^-16 degree.
    localparam longint ANG_HALF  = 64'sd11796480;
    localparam longint ANG_RIGHT = 64'sd5898240;
    localparam int     PRE_SH    = 14;
    localparam int     N_STEPS   = 23;
    localparam int     LATENCY   = 66;
    localparam longint CYCLE_LIMIT = 400000;

    // Expected contents of one joint angle transaction.
    typedef struct {
        logic signed [ANG_W-1:0] shoulder;
        logic signed [ANG_W-1:0] elbow;
        logic                    clamped;
        logic                    saturated;
    } t_joint;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;  // target_x, target_y
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;  // shoulder_angle, elbow_angle, padding
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;  // reach_clamped, acos_saturated
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_AW-1:0]       paddr;
    logic [CFG_DW-1:0]       pwdata;
    logic [CFG_DW-1:0]       prdata;
    logic                    pready;

    t_joint                  joint_queue[$];
    logic [LINK_W-1:0]       link_one;
    logic [LINK_W-1:0]       link_two;
    longint                  cycle_count;
    int                      error_count;
    int                      hold_off;
    int                      rx_wait;

    two_link_planar_ik u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Cycle counter with a hard limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Shift right rounding toward minus infinity.
    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    // Bitwise integer square root.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Arctangent of 2^-i in 2^-16 degree.
    function automatic longint atan_step(int i);
        longint tbl[N_STEPS];
        tbl = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return tbl[i];
    endfunction

    // Vectoring CORDIC: angle of (x, y) for x >= 0.
    function automatic longint cordic_angle(longint x, longint y);
        longint z;
        longint nx;
        longint ny;
        z = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + floor_sh(y, i);
                ny = y - floor_sh(x, i);
                z += atan_step(i);
            end else begin
                nx = x - floor_sh(y, i);
                ny = y + floor_sh(x, i);
                z -= atan_step(i);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Angle in 0..180 degrees of (n, s) with s >= 0.
    function automatic longint half_plane_angle(longint n, longint s);
        if (s == 0) return (n >= 0) ? 0 : ANG_HALF;
        if (n < 0) return ANG_RIGHT + cordic_angle(s, -n);
        return cordic_angle(n, s);
    endfunction

    // Joint angles for one target point under the current link lengths.
    function automatic t_joint solve_joints(logic signed [COORD_W-1:0] tx,
                                            logic signed [COORD_W-1:0] ty);
        t_joint r;
        longint x, y;
        longint unsigned a1, a2, reach2, s2, q, sq1, sq2, diff, diff2, k, big, p;
        longint n1, n3, n1s, n3s, root, phi1, phi3, base, sh, el;
        bit clamped, sat, zero1, zero3;
        int e;
        x = tx;
        y = ty;
        a1 = link_one;
        a2 = link_two;
        reach2 = (a1 + a2) * (a1 + a2);
        s2 = x * x + y * y;
        clamped = s2 > reach2;
        q = clamped ? reach2 : s2;
        sq1 = a1 * a1;
        sq2 = a2 * a2;
        diff = (a1 > a2) ? a1 - a2 : a2 - a1;
        diff2 = diff * diff;
        sat = q < diff2;
        zero1 = (a1 == 0) || (q == 0);
        zero3 = (a1 == 0) || (a2 == 0);
        n1 = longint'(sq1) + longint'(q) - longint'(sq2);
        n3 = longint'(sq1) + longint'(sq2) - longint'(q);
        n1s = 0;
        n3s = 0;
        root = 0;
        // Normalize operands by an even power of two before the square root.
        if (!sat && !(zero1 && zero3)) begin
            k = (reach2 - q) * (q - diff2);
            big = (q > sq2) ? q : sq2;
            p = sq1 * big;
            e = 0;
            while (e < 30 && p < (64'd1 << 56)) begin
                p <<= 2;
                e++;
            end
            root = isqrt(k << (2 * e));
            n1s = n1 <<< e;
            n3s = n3 <<< e;
        end
        if (zero1) phi1 = 0;
        else if (sat) phi1 = (n1 > 0) ? 0 : ANG_HALF;
        else phi1 = half_plane_angle(n1s, root);
        if (zero3) phi3 = 0;
        else if (sat) phi3 = (n3 > 0) ? 0 : ANG_HALF;
        else phi3 = half_plane_angle(n3s, root);
        // Base angle; the left half plane mirrors the elbow solution.
        if (x > 0) begin
            base = cordic_angle(x <<< PRE_SH, y <<< PRE_SH);
        end else if (x == 0) begin
            base = (y > 0) ? ANG_RIGHT : ((y < 0) ? -ANG_RIGHT : 0);
        end else begin
            base = ANG_HALF + cordic_angle((-x) <<< PRE_SH, (-y) <<< PRE_SH);
            phi1 = -phi1;
            phi3 = -phi3;
        end
        sh = floor_sh(phi1 + base + 128, 8);
        el = floor_sh(phi3 - ANG_HALF + 128, 8);
        r.shoulder = sh[ANG_W-1:0];
        r.elbow = el[ANG_W-1:0];
        r.clamped = clamped;
        r.saturated = sat && !(zero1 && zero3);
        return r;
    endfunction

    // Sends one target point, after a random gap, and records its expectation.
    task automatic send_point(logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ty, tx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        joint_queue.push_back(solve_joints(tx, ty));
    endtask

    // Lowers valid and waits until every expected result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (joint_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Writes one link length register through the configuration port.
    task automatic write_link(logic idx, logic [LINK_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= CFG_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LINK_ONE) link_one = value;
        else link_two = value;
    endtask

    // Random point, mostly within 1.5 reach lengths of the origin on each axis, sometimes full scale.
    task automatic send_random_point();
        int span;
        logic signed [COORD_W-1:0] tx, ty;
        span = int'(link_one) + int'(link_two);
        if (span > 16000 || $urandom_range(0, 4) == 0) begin
            tx = COORD_W'($urandom);
            ty = COORD_W'($urandom);
        end else begin
            tx = COORD_W'(int'($urandom_range(0, 3 * span)) - span - span / 2);
            ty = COORD_W'(int'($urandom_range(0, 3 * span)) - span - span / 2);
        end
        if ($urandom_range(0, 15) == 0) tx = 0;
        if ($urandom_range(0, 15) == 0) ty = 0;
        send_point(tx, ty);
    endtask

    // Edge values of the coordinates, the axes, the origin and the reach boundary.
    task automatic test_directed();
        logic signed [COORD_W-1:0] r;
        r = link_one + link_two;
        send_point(16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd100);
        send_point(16'sd0, -16'sd100);
        send_point(16'sd100, 16'sd0);
        send_point(-16'sd100, 16'sd0);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(-16'sd32768, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);
        send_point(r, 16'sd0);
        send_point(r + 16'sd1, 16'sd0);
        send_point(-r, 16'sd0);
        send_point(16'sd0, r);
        send_point(16'sd10, 16'sd10);
        send_point(-16'sd500, 16'sd300);
        send_point(-16'sd500, -16'sd300);
        send_point(16'sd768, 16'sd0);
        send_point(16'sd1, -16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(16'sd1200, -16'sd900);
        drain();
    endtask

    // Random points under the given link lengths.
    task automatic test_random(logic [LINK_W-1:0] l1, logic [LINK_W-1:0] l2, int count);
        write_link(REG_LINK_ONE, l1);
        write_link(REG_LINK_TWO, l2);
        for (int i = 0; i < count; i++) send_random_point();
        drain();
    endtask

    // The receiver stalls for a long stretch while points keep arriving.
    task automatic test_backpressure();
        hold_off = 200;
        for (int i = 0; i < 90; i++) send_random_point();
        drain();
    endtask

    // Receiver: a random wait after some accepted results, plus long hold-offs.
    always @(posedge i_clk) begin
        int draw;
        draw = $urandom_range(0, 5);
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && draw > 0 &&
                     cycle_count % 800 >= 150) begin
            rx_wait <= draw - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_joint want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (joint_queue.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                error_count++;
            end else begin
                want = joint_queue.pop_front();
                if (m_axis_tdata[ANG_W-1:0] !== want.shoulder) begin
                    $error("shoulder_angle expected %0d actual %0d", want.shoulder,
                           $signed(m_axis_tdata[ANG_W-1:0]));
                    error_count++;
                end
                if (m_axis_tdata[2*ANG_W-1:ANG_W] !== want.elbow) begin
                    $error("elbow_angle expected %0d actual %0d", want.elbow,
                           $signed(m_axis_tdata[2*ANG_W-1:ANG_W]));
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.clamped) begin
                    $error("reach_clamped expected %0b actual %0b", want.clamped,
                           m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.saturated) begin
                    $error("acos_saturated expected %0b actual %0b", want.saturated,
                           m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        cycle_count = 0;
        error_count = 0;
        hold_off = 0;
        link_one = LINK_ONE_RST;
        link_two = LINK_TWO_RST;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(LINK_ONE_RST, LINK_TWO_RST, 90);
        test_random(15'd1, 15'd1, 30);
        test_random(15'd32767, 15'd32767, 30);
        test_random(15'd2000, 15'd1, 40);
        test_random(15'd3, 15'd2500, 40);
        test_random(15'd700, 15'd700, 40);
        test_backpressure();
        test_random(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)), 40);
        if (error_count == 0 && joint_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
